// ----- rtl/core/srbd_pkg.sv -----
// ----------------------------------------------------------------------------
// srbd_pkg
// Shared types and codes for the sample ring buffer with repeat suppression.
// ----------------------------------------------------------------------------
package srbd_pkg;

    localparam int AXIS_W  = 16;
    localparam int STAMP_W = 32;

    typedef enum logic [2:0] {
        STATUS_STORED      = 3'd0,
        STATUS_REPEAT      = 3'd1,
        STATUS_STORED_LOST = 3'd2,
        STATUS_POPPED      = 3'd3,
        STATUS_EMPTY       = 3'd4
    } status_t;

    // where the result record comes from
    typedef enum logic [1:0] {
        SRC_ZERO   = 2'd0,
        SRC_MEM    = 2'd1,
        SRC_NEWEST = 2'd2
    } src_t;

    typedef struct packed {
        logic signed [AXIS_W-1:0]  accel_x;
        logic signed [AXIS_W-1:0]  accel_y;
        logic signed [AXIS_W-1:0]  accel_z;
        logic signed [AXIS_W-1:0]  gyro_x;
        logic signed [AXIS_W-1:0]  gyro_y;
        logic signed [AXIS_W-1:0]  gyro_z;
        logic        [STAMP_W-1:0] stamp;
    } record_t;

    typedef struct packed {
        status_t status;
        src_t    src;
    } decision_t;

endpackage

// ----- rtl/core/srbd_ring_mem.sv -----
// ----------------------------------------------------------------------------
// srbd_ring_mem
// Record storage: one write port, one registered read port, per-slot valid
// bits so that slots never written read as zero.
// ----------------------------------------------------------------------------
module srbd_ring_mem #(
    parameter int RING_DEPTH = 5,
    parameter int IDX_W      = 3
) (
    input  logic                   clk,
    input  logic                   rst_n,
    input  logic                   wr_en,
    input  logic [IDX_W-1:0]       wr_addr,
    input  srbd_pkg::record_t      wr_data,
    input  logic                   rd_en,
    input  logic [IDX_W-1:0]       rd_addr,
    output srbd_pkg::record_t      rd_data
);

    srbd_pkg::record_t mem [RING_DEPTH];
    logic [RING_DEPTH-1:0] valid_reg;
    srbd_pkg::record_t     rd_data_reg;
    logic                  rd_valid_reg;

    always_ff @(posedge clk)
    begin
        if (wr_en)
        begin
            mem[wr_addr] <= wr_data;
        end
        if (rd_en)
        begin
            rd_data_reg <= mem[rd_addr];
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            valid_reg    <= '0;
            rd_valid_reg <= 1'b0;
        end
        else
        begin
            if (wr_en)
            begin
                valid_reg[wr_addr] <= 1'b1;
            end
            if (rd_en)
            begin
                rd_valid_reg <= valid_reg[rd_addr];
            end
        end
    end

    assign rd_data = rd_valid_reg ? rd_data_reg : '0;

endmodule

// ----- rtl/core/srbd_ctrl.sv -----
// ----------------------------------------------------------------------------
// srbd_ctrl
// Ring indices, newest-record copy, repeat compare and push/pop decision.
// ----------------------------------------------------------------------------
module srbd_ctrl #(
    parameter int RING_DEPTH = 5,
    parameter int IDX_W      = 3
) (
    input  logic                   clk,
    input  logic                   rst_n,
    input  logic                   accept,
    input  logic                   func,
    input  srbd_pkg::record_t      rec,
    output logic                   wr_en,
    output logic [IDX_W-1:0]       wr_addr,
    output logic [IDX_W-1:0]       rd_addr,
    output srbd_pkg::record_t      newest,
    output srbd_pkg::decision_t    decision
);

    localparam logic [IDX_W-1:0] LAST_IDX = IDX_W'(RING_DEPTH - 1);

    logic [IDX_W-1:0]  write_idx_reg, write_idx_next;
    logic [IDX_W-1:0]  oldest_idx_reg, oldest_idx_next;
    srbd_pkg::record_t newest_reg;
    logic [IDX_W-1:0]  write_adv, oldest_adv;
    logic              match;
    logic              store;

    assign write_adv  = (write_idx_reg == LAST_IDX) ? '0 : write_idx_reg + 1'b1;
    assign oldest_adv = (oldest_idx_reg == LAST_IDX) ? '0 : oldest_idx_reg + 1'b1;

    // stamp is not part of the repeat compare
    assign match = (rec.accel_x == newest_reg.accel_x) && (rec.accel_y == newest_reg.accel_y)
                && (rec.accel_z == newest_reg.accel_z) && (rec.gyro_x == newest_reg.gyro_x)
                && (rec.gyro_y == newest_reg.gyro_y) && (rec.gyro_z == newest_reg.gyro_z);

    always_comb
    begin
        write_idx_next  = write_idx_reg;
        oldest_idx_next = oldest_idx_reg;
        store           = 1'b0;
        decision.src    = srbd_pkg::SRC_ZERO;
        decision.status = srbd_pkg::STATUS_STORED;
        if (!func)
        begin
            if (match)
            begin
                decision.status = srbd_pkg::STATUS_REPEAT;
            end
            else
            begin
                store          = 1'b1;
                write_idx_next = write_adv;
                if (write_adv == oldest_idx_reg)
                begin
                    // full: drop the oldest record
                    oldest_idx_next = oldest_adv;
                    decision.status = srbd_pkg::STATUS_STORED_LOST;
                end
            end
        end
        else if (oldest_idx_reg == write_idx_reg)
        begin
            decision.src    = srbd_pkg::SRC_NEWEST;
            decision.status = srbd_pkg::STATUS_EMPTY;
        end
        else
        begin
            decision.src    = srbd_pkg::SRC_MEM;
            decision.status = srbd_pkg::STATUS_POPPED;
            oldest_idx_next = oldest_adv;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            write_idx_reg  <= '0;
            oldest_idx_reg <= '0;
            newest_reg     <= '0;
        end
        else if (accept)
        begin
            write_idx_reg  <= write_idx_next;
            oldest_idx_reg <= oldest_idx_next;
            if (store)
            begin
                newest_reg <= rec;
            end
        end
    end

    assign wr_en   = accept && store;
    assign wr_addr = write_idx_reg;
    assign rd_addr = oldest_idx_reg;
    assign newest  = newest_reg;

endmodule

// ----- rtl/core/sample_ring_buffer_dedup_overwrite_core.sv -----
// ----------------------------------------------------------------------------
// sample_ring_buffer_dedup_overwrite_core
// Ring of motion-sensor records with repeat drop and overwrite of the oldest.
// ----------------------------------------------------------------------------
//  channel | handshake             | payload
//  --------+-----------------------+----------------------------------------
//  input   | in_valid / in_stall   | func, accel_x..gyro_z, stamp
//  output  | out_valid / out_stall | status, out_accel_x..out_gyro_z, out_stamp
//
//  One item per cycle unless a result is stalled: each transfer is decided in the
//  cycle it arrives and its result appears in the output register on the next cycle.
//  The pop read uses the single registered read port of the record memory.
//  Reset clears indices and slot valid bits; unwritten slots read as zero.
//  A stalled result holds; input is taken while the result is being taken.
// ----------------------------------------------------------------------------
module sample_ring_buffer_dedup_overwrite_core #(
    parameter int RING_DEPTH = 5
) (
    input  logic               clk,
    input  logic               rst_n,
    input  logic               in_valid,
    output logic               in_stall,
    input  logic               func,
    input  logic signed [15:0] accel_x,
    input  logic signed [15:0] accel_y,
    input  logic signed [15:0] accel_z,
    input  logic signed [15:0] gyro_x,
    input  logic signed [15:0] gyro_y,
    input  logic signed [15:0] gyro_z,
    input  logic        [31:0] stamp,
    output logic               out_valid,
    input  logic               out_stall,
    output logic        [2:0]  status,
    output logic signed [15:0] out_accel_x,
    output logic signed [15:0] out_accel_y,
    output logic signed [15:0] out_accel_z,
    output logic signed [15:0] out_gyro_x,
    output logic signed [15:0] out_gyro_y,
    output logic signed [15:0] out_gyro_z,
    output logic        [31:0] out_stamp
);

    localparam int IDX_W = $clog2(RING_DEPTH);

    logic                  accept;
    srbd_pkg::record_t     in_rec;
    logic                  wr_en;
    logic [IDX_W-1:0]      wr_addr;
    logic [IDX_W-1:0]      rd_addr;
    srbd_pkg::record_t     newest;
    srbd_pkg::decision_t   decision;
    srbd_pkg::record_t     mem_rd;
    srbd_pkg::record_t     out_rec;

    logic                  out_valid_reg;
    srbd_pkg::status_t     status_reg;
    logic                  from_mem_reg;
    srbd_pkg::record_t     hold_rec_reg;

    assign in_stall = out_valid_reg && out_stall;
    assign accept   = in_valid && !in_stall;

    assign in_rec.accel_x = accel_x;
    assign in_rec.accel_y = accel_y;
    assign in_rec.accel_z = accel_z;
    assign in_rec.gyro_x  = gyro_x;
    assign in_rec.gyro_y  = gyro_y;
    assign in_rec.gyro_z  = gyro_z;
    assign in_rec.stamp   = stamp;

    srbd_ctrl #(
        .RING_DEPTH (RING_DEPTH),
        .IDX_W      (IDX_W)
    ) u_ctrl (
        .clk      (clk),
        .rst_n    (rst_n),
        .accept   (accept),
        .func     (func),
        .rec      (in_rec),
        .wr_en    (wr_en),
        .wr_addr  (wr_addr),
        .rd_addr  (rd_addr),
        .newest   (newest),
        .decision (decision)
    );

    srbd_ring_mem #(
        .RING_DEPTH (RING_DEPTH),
        .IDX_W      (IDX_W)
    ) u_mem (
        .clk     (clk),
        .rst_n   (rst_n),
        .wr_en   (wr_en),
        .wr_addr (wr_addr),
        .wr_data (in_rec),
        .rd_en   (accept),
        .rd_addr (rd_addr),
        .rd_data (mem_rd)
    );

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            out_valid_reg <= 1'b0;
            status_reg    <= srbd_pkg::STATUS_STORED;
            from_mem_reg  <= 1'b0;
        end
        else
        begin
            if (accept)
            begin
                out_valid_reg <= 1'b1;
                status_reg    <= decision.status;
                from_mem_reg  <= (decision.src == srbd_pkg::SRC_MEM);
            end
            else if (!out_stall)
            begin
                out_valid_reg <= 1'b0;
            end
        end
    end

    // push results carry zeros; empty pop carries the newest record
    always_ff @(posedge clk)
    begin
        if (accept)
        begin
            hold_rec_reg <= (decision.src == srbd_pkg::SRC_NEWEST) ? newest : '0;
        end
    end

    assign out_rec     = from_mem_reg ? mem_rd : hold_rec_reg;
    assign out_valid   = out_valid_reg;
    assign status      = status_reg;
    assign out_accel_x = out_rec.accel_x;
    assign out_accel_y = out_rec.accel_y;
    assign out_accel_z = out_rec.accel_z;
    assign out_gyro_x  = out_rec.gyro_x;
    assign out_gyro_y  = out_rec.gyro_y;
    assign out_gyro_z  = out_rec.gyro_z;
    assign out_stamp   = out_rec.stamp;

endmodule

// ----- sim/sample_ring_monitor.sv -----
`timescale 1ns / 100ps
// ----------------------------------------------------------------------------
// sample_ring_monitor
// Watches both channels of the sample ring core. It keeps its own copy of
// the record ring to work out each result, and compares results in order.
// ----------------------------------------------------------------------------
module sample_ring_monitor #(
    parameter int RING_DEPTH = 5
) (
    input  logic               clk,
    input  logic               rst_n,
    input  logic               in_valid,
    input  logic               in_stall,
    input  logic               func,
    input  logic signed [15:0] accel_x,
    input  logic signed [15:0] accel_y,
    input  logic signed [15:0] accel_z,
    input  logic signed [15:0] gyro_x,
    input  logic signed [15:0] gyro_y,
    input  logic signed [15:0] gyro_z,
    input  logic        [31:0] stamp,
    input  logic               out_valid,
    input  logic               out_stall,
    input  logic        [2:0]  status,
    input  logic signed [15:0] out_accel_x,
    input  logic signed [15:0] out_accel_y,
    input  logic signed [15:0] out_accel_z,
    input  logic signed [15:0] out_gyro_x,
    input  logic signed [15:0] out_gyro_y,
    input  logic signed [15:0] out_gyro_z,
    input  logic        [31:0] out_stamp,
    output int                 errors,
    output int                 checked,
    output int                 awaited,
    output logic        [4:0]  status_seen
);

    typedef struct packed {
        srbd_pkg::status_t status;
        srbd_pkg::record_t rec;
    } ring_result_t;

    srbd_pkg::record_t ring_slot [RING_DEPTH];
    int unsigned       oldest_slot;
    int unsigned       write_slot;
    ring_result_t      awaited_results [$];

    function automatic int unsigned slot_after(input int unsigned i);
        return (i + 1 >= RING_DEPTH) ? 0 : i + 1;
    endfunction

    function automatic int unsigned slot_before(input int unsigned i);
        return (i == 0) ? RING_DEPTH - 1 : i - 1;
    endfunction

    // Apply one push or pop to the ring copy and return the result it causes.
    function automatic ring_result_t ring_step(input logic do_pop,
                                               input srbd_pkg::record_t rec);
        ring_result_t res;
        int unsigned  newest;
        res    = '0;
        newest = slot_before(write_slot);
        if (!do_pop) begin
            // the time stamp takes no part in the repeat test
            if (ring_slot[newest][127:32] == rec[127:32]) begin
                res.status = srbd_pkg::STATUS_REPEAT;
            end else begin
                ring_slot[write_slot] = rec;
                write_slot = slot_after(write_slot);
                if (write_slot == oldest_slot) begin
                    oldest_slot = slot_after(oldest_slot);
                    res.status  = srbd_pkg::STATUS_STORED_LOST;
                end else begin
                    res.status = srbd_pkg::STATUS_STORED;
                end
            end
        end else if (oldest_slot == write_slot) begin
            // empty: repeat the newest slot, remove nothing
            res.rec    = ring_slot[newest];
            res.status = srbd_pkg::STATUS_EMPTY;
        end else begin
            res.rec     = ring_slot[oldest_slot];
            oldest_slot = slot_after(oldest_slot);
            res.status  = srbd_pkg::STATUS_POPPED;
        end
        return res;
    endfunction

    task automatic check_field(input string name, input logic [31:0] want,
                               input logic [31:0] got);
        if (want !== got) begin
            $display("%0t: %s mismatch, expected %h, actual %h", $time, name, want, got);
            errors++;
        end
    endtask

    always @(posedge clk or negedge rst_n) begin
        ring_result_t      want;
        srbd_pkg::record_t rec;
        if (!rst_n) begin
            for (int i = 0; i < RING_DEPTH; i++)
                ring_slot[i] = '0;
            oldest_slot = 0;
            write_slot  = 0;
            awaited_results.delete();
            errors      = 0;
            checked     = 0;
            status_seen = '0;
        end else begin
            if (out_valid && !out_stall) begin
                if (awaited_results.size() == 0) begin
                    $display("%0t: result transfer with none expected, actual status %0d",
                             $time, status);
                    errors++;
                end else begin
                    want = awaited_results.pop_front();
                    check_field("status", 32'(want.status), 32'(status));
                    check_field("out_accel_x", 32'(want.rec.accel_x), 32'(out_accel_x));
                    check_field("out_accel_y", 32'(want.rec.accel_y), 32'(out_accel_y));
                    check_field("out_accel_z", 32'(want.rec.accel_z), 32'(out_accel_z));
                    check_field("out_gyro_x", 32'(want.rec.gyro_x), 32'(out_gyro_x));
                    check_field("out_gyro_y", 32'(want.rec.gyro_y), 32'(out_gyro_y));
                    check_field("out_gyro_z", 32'(want.rec.gyro_z), 32'(out_gyro_z));
                    check_field("out_stamp", want.rec.stamp, out_stamp);
                    status_seen[want.status] = 1'b1;
                    checked++;
                end
            end
            if (in_valid && !in_stall) begin
                rec = {accel_x, accel_y, accel_z, gyro_x, gyro_y, gyro_z, stamp};
                awaited_results.push_back(ring_step(func, rec));
            end
        end
        awaited = awaited_results.size();
    end

endmodule

// ----- sim/tb_sample_ring_buffer_dedup_overwrite_core.sv -----
`timescale 1ns / 100ps
// ----------------------------------------------------------------------------
// tb_sample_ring_buffer_dedup_overwrite_core
// Drives push and pop transfers into the sample ring core: a directed run
// through repeats, overflow and empty pops, then random bursts under four
// mixes of sender gaps and receiver stalls. The monitor checks every result.
// ----------------------------------------------------------------------------
module tb_sample_ring_buffer_dedup_overwrite_core;

    localparam int RING_DEPTH  = 5;
    localparam int ITEM_TARGET = 750;
    localparam int MIX_COUNT   = 4;
    localparam logic OP_PUSH   = 1'b0;
    localparam logic OP_POP    = 1'b1;

    logic               clk;
    logic               rst_n;
    logic               in_valid;
    logic               in_stall;
    logic               func;
    logic signed [15:0] accel_x;
    logic signed [15:0] accel_y;
    logic signed [15:0] accel_z;
    logic signed [15:0] gyro_x;
    logic signed [15:0] gyro_y;
    logic signed [15:0] gyro_z;
    logic        [31:0] stamp;
    logic               out_valid;
    logic               out_stall;
    logic        [2:0]  status;
    logic signed [15:0] out_accel_x;
    logic signed [15:0] out_accel_y;
    logic signed [15:0] out_accel_z;
    logic signed [15:0] out_gyro_x;
    logic signed [15:0] out_gyro_y;
    logic signed [15:0] out_gyro_z;
    logic        [31:0] out_stamp;

    int                 errors;
    int                 checked;
    int                 awaited;
    logic        [4:0]  status_seen;

    int                 idle_pct;
    int                 stall_pct;
    int                 pushes_sent;
    int                 pops_sent;
    srbd_pkg::record_t  last_pushed;

    sample_ring_buffer_dedup_overwrite_core #(
        .RING_DEPTH(RING_DEPTH)
    ) dut (.*);

    sample_ring_monitor #(
        .RING_DEPTH(RING_DEPTH)
    ) monitor (.*);

    initial clk = 1'b0;
    always #10 clk = ~clk;

    always @(posedge clk or negedge rst_n) begin
        if (!rst_n)
            out_stall <= 1'b0;
        else
            out_stall <= ($urandom_range(0, 99) < stall_pct);
    end

    initial begin
        #4_000_000;
        $display("tb_sample_ring_buffer_dedup_overwrite_core: FAIL");
        $finish;
    end

    function automatic logic signed [15:0] pick_axis();
        case ($urandom_range(0, 7))
            0:       return 16'sh8000;
            1:       return 16'sh7FFF;
            2:       return 16'sh0000;
            3:       return 16'shFFFF;
            default: return 16'($urandom);
        endcase
    endfunction

    function automatic srbd_pkg::record_t random_record();
        srbd_pkg::record_t rec;
        rec.accel_x = pick_axis();
        rec.accel_y = pick_axis();
        rec.accel_z = pick_axis();
        rec.gyro_x  = pick_axis();
        rec.gyro_y  = pick_axis();
        rec.gyro_z  = pick_axis();
        rec.stamp   = $urandom;
        return rec;
    endfunction

    function automatic srbd_pkg::record_t make_record(
        input int ax, input int ay, input int az,
        input int gx, input int gy, input int gz,
        input int st);
        return {16'(ax), 16'(ay), 16'(az), 16'(gx), 16'(gy), 16'(gz), 32'(st)};
    endfunction

    // Hold the transfer until accepted; the gap before it follows idle_pct.
    task automatic send_item(input logic op, input srbd_pkg::record_t rec);
        while ($urandom_range(0, 99) < idle_pct) begin
            in_valid <= 1'b0;
            @(posedge clk);
        end
        in_valid <= 1'b1;
        func     <= op;
        accel_x  <= rec.accel_x;
        accel_y  <= rec.accel_y;
        accel_z  <= rec.accel_z;
        gyro_x   <= rec.gyro_x;
        gyro_y   <= rec.gyro_y;
        gyro_z   <= rec.gyro_z;
        stamp    <= rec.stamp;
        @(posedge clk);
        while (in_stall)
            @(posedge clk);
        if (op == OP_PUSH) begin
            last_pushed = rec;
            pushes_sent++;
        end else begin
            pops_sent++;
        end
    endtask

    initial begin
        srbd_pkg::record_t rec;
        int                push_bias;
        rst_n       = 1'b0;
        in_valid    = 1'b0;
        out_stall   = 1'b0;
        func        = OP_PUSH;
        accel_x     = '0;
        accel_y     = '0;
        accel_z     = '0;
        gyro_x      = '0;
        gyro_y      = '0;
        gyro_z      = '0;
        stamp       = '0;
        idle_pct    = 0;
        stall_pct   = 0;
        pushes_sent = 0;
        pops_sent   = 0;
        push_bias   = 50;
        last_pushed = '0;
        repeat (12) @(posedge clk);
        rst_n <= 1'b1;
        @(posedge clk);

        // pop of the fresh ring, then an all-zero push that matches the cleared store
        send_item(OP_POP, '0);
        send_item(OP_PUSH, '0);
        send_item(OP_PUSH, make_record(32767, 32767, 32767, 32767, 32767, 32767,
                                       32'hFFFF_FFFF));
        // same axes, other stamp: still a repeat
        send_item(OP_PUSH, make_record(32767, 32767, 32767, 32767, 32767, 32767, 0));
        send_item(OP_PUSH, make_record(-32768, -32768, -32768, -32768, -32768, -32768, 0));
        send_item(OP_PUSH, make_record(-32768, -32768, -32768, -32768, -32768, -32767,
                                       32'h0000_0001));
        send_item(OP_PUSH, make_record(1, -1, 2, -2, 3, -3, 32'h8000_0001));
        // ring is full: this one drops the oldest and wraps the write slot
        send_item(OP_PUSH, make_record(-1, -1, -1, -1, -1, -1, 32'h7FFF_FFFF));
        repeat (4) send_item(OP_POP, random_record());
        // empty pops repeat the newest slot across the wrap
        repeat (2) send_item(OP_POP, random_record());
        send_item(OP_PUSH, make_record(-1, -1, -1, -1, -1, -1, 32'h1234_5678));
        send_item(OP_PUSH, '0);
        send_item(OP_POP, '0);

        for (int mix = 0; mix < MIX_COUNT; mix++) begin
            case (mix)
                0: begin idle_pct = 0;  stall_pct = 0;  end
                1: begin idle_pct = 64; stall_pct = 0;  end
                2: begin idle_pct = 0;  stall_pct = 64; end
                default: begin idle_pct = 19; stall_pct = 19; end
            endcase
            for (int n = 0; n < ITEM_TARGET / MIX_COUNT; n++) begin
                // bursts lean toward filling, draining or neither
                if (n % 8 == 0)
                    push_bias = ($urandom_range(0, 2) == 0) ? 85 :
                                ($urandom_range(0, 1) == 0) ? 20 : 55;
                if ($urandom_range(0, 99) >= push_bias) begin
                    send_item(OP_POP, random_record());
                end else begin
                    case ($urandom_range(0, 9))
                        0, 1: begin
                            rec       = last_pushed;
                            rec.stamp = $urandom;
                        end
                        2, 3: begin
                            // differ from the newest in a single axis bit
                            rec = last_pushed;
                            rec[32 + $urandom_range(0, 95)] ^= 1'b1;
                            rec.stamp = $urandom;
                        end
                        default: rec = random_record();
                    endcase
                    send_item(OP_PUSH, rec);
                end
            end
        end
        in_valid <= 1'b0;

        // let the monitor log the last transfer before reading its count
        @(negedge clk);
        while (awaited != 0)
            @(negedge clk);
        repeat (4) @(posedge clk);

        $display("Sent %0d pushes and %0d pops over four gap/stall mixes; %0d results checked.",
                 pushes_sent, pops_sent, checked);
        $display("Result kinds seen (empty, popped, lost, repeat, stored): %b", status_seen);
        if (errors == 0)
            $display("tb_sample_ring_buffer_dedup_overwrite_core: PASS");
        else
            $display("tb_sample_ring_buffer_dedup_overwrite_core: FAIL");
        $finish;
    end

endmodule
